@@ rtl/core/assert_macros.svh @@
// Assertion macros included by the core RTL file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ rtl/core/ttw_pkg.sv @@
`default_nettype none

package ttw_pkg;

   localparam int TIME_W = 40;
   localparam int SPEED_W = 32;
   localparam int ARREST_W = 16;
   localparam int SPAC_W = 31;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [TIME_W-1:0] ONE_CYCLE = TIME_W'(65536);

   localparam logic [ARREST_W-1:0] MIN_ARREST_RESET = ARREST_W'(1000);
   localparam logic [SPAC_W-1:0] SPAC_RESET = SPAC_W'(1000);

   typedef enum logic [2:0] {
      CMD_SPEED   = 3'd0,
      CMD_TICK    = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_RESUME  = 3'd3,
      CMD_RESTART = 3'd4
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_MIN_ARREST     = 1'b0,
      CSR_SPEED_PER_STEP = 1'b1
   } csr_index_type;

   typedef logic [TIME_W-1:0] time_type;

   function automatic time_type sat_add(input time_type a, input time_type b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/trajectory_time_warp_core.sv @@
`default_nettype none
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_cmd, req_motor_index, req_motor_speed
// rsp       out        rsp_valid/rsp_stall  rsp_traj_time, rsp_stopped, rsp_stopping,
//                                           rsp_resuming
// csr       in         csr_we               csr_index, csr_wdata
//
// A tick that warps time runs the 32-step bit-serial divider.
// A stop reads one speed entry per cycle, then the divider runs.
// Other commands go straight to ST_FINISH; a tick without a division ends after ST_TICK_A or
// ST_TICK_B, or at zero arrest after the table lookup. req_stall falls as rsp_valid rises.
// Reset is synchronous; all speed entries read as zero until written after reset.
// A new transfer is taken while a result still waits on a stalled output.

`include "assert_macros.svh"

module trajectory_time_warp_core #(
   parameter int MOTORS = 8,
   parameter int EXP_ENTRIES = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [2:0]                    req_cmd,
   input  wire logic [2:0]                    req_motor_index,
   input  wire logic signed [31:0]            req_motor_speed,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ttw_pkg::TIME_W-1:0]         rsp_traj_time,
   output logic                               rsp_stopped,
   output logic                               rsp_stopping,
   output logic                               rsp_resuming,
   input  wire logic                          csr_we,
   input  wire logic [0:0]                    csr_index,
   input  wire logic [ttw_pkg::SPAC_W-1:0]    csr_wdata
);

   import ttw_pkg::*;

   localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int IDX_W = $clog2(EXP_ENTRIES);
   localparam int PROD_W = IDX_W + 18;
   localparam logic [IDX_W-1:0] TAB_LAST = IDX_W'(EXP_ENTRIES - 1);
   localparam logic [MIDX_W-1:0] SCAN_LAST = MIDX_W'(MOTORS - 1);

   typedef logic [16:0] tab_type [EXP_ENTRIES];

   function automatic tab_type build_tab();
      logic [63:0] t;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      tab_type tab;
      t = (64'd5 << 32) / 64'(EXP_ENTRIES - 1);
      term = 64'd1 << 32;
      sum = term;
      v = term;
      for (int n = 1; n <= 16; n++) begin
         term = ((term * t) >> 32) / 64'(n);
         if ((n & 1) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum >= (64'd1 << 32)) begin
         sum = (64'd1 << 32) - 64'd1;
      end
      tab[0] = 17'd65536;
      for (int k = 1; k < EXP_ENTRIES; k++) begin
         v = (v * sum + (64'd1 << 31)) >> 32;
         tab[k] = 17'((v + (64'd1 << 15)) >> 16);
      end
      return tab;
   endfunction

   localparam tab_type EXP_TAB = build_tab();

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_STOP_LOAD,
      ST_DIV,
      ST_STOP_FIN,
      ST_TICK_A,
      ST_TICK_B,
      ST_TICK_IDX,
      ST_TICK_ROM,
      ST_TICK_ADD,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [ARREST_W-1:0] min_ff, min_in;
   logic [SPAC_W-1:0] spac_ff, spac_in;
   logic [MOTORS-1:0] valid_ff, valid_in;
   time_type warped_ff, warped_in;
   time_type real_ff, real_in;
   time_type mark_ff, mark_in;
   logic [ARREST_W-1:0] arrest_ff, arrest_in;
   logic halted_ff, halted_in;
   logic stop_ff, stop_in;
   logic resume_ff, resume_in;
   logic fresh_ff, fresh_in;
   logic rsp_valid_ff, rsp_valid_in;
   time_type rsp_time_ff, rsp_time_in;
   logic rsp_stopped_ff, rsp_stopped_in;
   logic rsp_stopping_ff, rsp_stopping_in;
   logic rsp_resuming_ff, rsp_resuming_in;
   logic rd_live_ff, rd_live_in;
   logic [MIDX_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [4:0] div_cnt_ff, div_cnt_in;
   logic div_stop_ff, div_stop_in;

   logic [31:0] div_num_ff, div_num_in;
   logic [SPAC_W-1:0] div_den_ff, div_den_in;
   logic [30:0] div_rem_ff, div_rem_in;
   logic [31:0] div_quo_ff, div_quo_in;
   logic [31:0] max_ff, max_in;
   logic [IDX_W-1:0] tab_idx_ff, tab_idx_in;
   logic [16:0] tab_val_ff;
   logic signed [SPEED_W-1:0] rd_data_ff;
   logic rd_ok_ff;

   logic signed [SPEED_W-1:0] speed_mem [MOTORS];

   logic req_accept;
   logic mem_we;
   logic [MIDX_W-1:0] mem_addr;
   logic [31:0] trial;
   logic [32:0] diff;
   logic [SPEED_W-1:0] scan_val;
   logic [31:0] mag;
   logic [31:0] span;
   time_type elapsed;
   logic [16:0] u_sel;
   logic [PROD_W-1:0] prod;
   logic [IDX_W+1:0] idx_wide;
   logic [ARREST_W-1:0] q_sat;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign mem_addr = MIDX_W'(req_motor_index);
   assign mem_we = req_accept && (cmd_type'(req_cmd) == CMD_SPEED)
                   && (7'(req_motor_index) < 7'(MOTORS));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_traj_time = rsp_time_ff;
   assign rsp_stopped = rsp_stopped_ff;
   assign rsp_stopping = rsp_stopping_ff;
   assign rsp_resuming = rsp_resuming_ff;

   assign trial = {div_rem_ff, div_num_ff[31]};
   assign diff = {1'b0, trial} - {2'b00, div_den_ff};

   assign scan_val = rd_ok_ff ? rd_data_ff : '0;
   assign mag = scan_val[SPEED_W-1] ? (~scan_val + 32'd1) : scan_val;

   assign span = {arrest_ff, 16'h0000};
   assign elapsed = (real_ff >= mark_ff) ? (real_ff - mark_ff) : '0;

   assign u_sel = (arrest_ff == '0) ? '0 : div_quo_ff[16:0];
   assign prod = PROD_W'(u_sel) * PROD_W'(TAB_LAST) + PROD_W'(32768);
   assign idx_wide = prod[PROD_W-1:16];

   assign q_sat = (div_quo_ff[31:16] != '0) ? {ARREST_W{1'b1}} : div_quo_ff[15:0];

   always_comb begin
      state_in = state_ff;
      min_in = min_ff;
      spac_in = spac_ff;
      valid_in = valid_ff;
      warped_in = warped_ff;
      real_in = real_ff;
      mark_in = mark_ff;
      arrest_in = arrest_ff;
      halted_in = halted_ff;
      stop_in = stop_ff;
      resume_in = resume_ff;
      fresh_in = fresh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_time_in = rsp_time_ff;
      rsp_stopped_in = rsp_stopped_ff;
      rsp_stopping_in = rsp_stopping_ff;
      rsp_resuming_in = rsp_resuming_ff;
      rd_live_in = 1'b0;
      scan_cnt_in = scan_cnt_ff;
      div_cnt_in = div_cnt_ff;
      div_stop_in = div_stop_ff;
      div_num_in = div_num_ff;
      div_den_in = div_den_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      max_in = max_ff;
      tab_idx_in = tab_idx_ff;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_ARREST: min_in = csr_wdata[ARREST_W-1:0];
            CSR_SPEED_PER_STEP: spac_in = csr_wdata;
            default: ;
         endcase
      end

      if (mem_we) begin
         valid_in[mem_addr] = 1'b1;
      end

      if (rd_live_ff && (mag > max_ff)) begin
         max_in = mag;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_FINISH;
               case (cmd_type'(req_cmd))
                  CMD_TICK: state_in = ST_TICK_A;
                  CMD_STOP: begin
                     state_in = ST_SCAN;
                     scan_cnt_in = '0;
                     max_in = '0;
                  end
                  CMD_RESUME: begin
                     halted_in = 1'b0;
                     resume_in = 1'b1;
                     real_in = '0;
                  end
                  CMD_RESTART: begin
                     halted_in = 1'b0;
                     stop_in = 1'b0;
                     resume_in = 1'b0;
                     fresh_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            rd_live_in = 1'b1;
            scan_cnt_in = scan_cnt_ff + MIDX_W'(1);
            if (scan_cnt_ff == SCAN_LAST) begin
               state_in = ST_SCAN_LAST;
            end
         end
         ST_SCAN_LAST: begin
            state_in = ST_STOP_LOAD;
         end
         ST_STOP_LOAD: begin
            div_num_in = max_ff;
            div_den_in = spac_ff;
            div_rem_in = '0;
            div_quo_in = '0;
            div_cnt_in = '0;
            div_stop_in = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_num_in = {div_num_ff[30:0], 1'b0};
            div_quo_in = {div_quo_ff[30:0], !diff[32]};
            div_rem_in = diff[32] ? trial[30:0] : diff[30:0];
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               state_in = div_stop_ff ? ST_STOP_FIN : ST_TICK_IDX;
            end
         end
         ST_STOP_FIN: begin
            stop_in = 1'b1;
            mark_in = real_ff;
            warped_in = real_ff;
            arrest_in = (q_sat > min_ff) ? q_sat : min_ff;
            state_in = ST_FINISH;
         end
         ST_TICK_A: begin
            if (halted_ff) begin
               state_in = ST_FINISH;
            end else if (fresh_ff) begin
               fresh_in = 1'b0;
               warped_in = '0;
               real_in = '0;
               mark_in = '0;
               state_in = ST_FINISH;
            end else begin
               real_in = sat_add(real_ff, ONE_CYCLE);
               state_in = ST_TICK_B;
            end
         end
         ST_TICK_B: begin
            div_den_in = SPAC_W'(arrest_ff);
            div_rem_in = '0;
            div_quo_in = '0;
            div_cnt_in = '0;
            div_stop_in = 1'b0;
            state_in = ST_FINISH;
            if (stop_ff) begin
               if (elapsed <= TIME_W'(span)) begin
                  div_num_in = elapsed[31:0];
                  state_in = (arrest_ff == '0) ? ST_TICK_IDX : ST_DIV;
               end else begin
                  halted_in = 1'b1;
                  stop_in = 1'b0;
               end
            end else if (resume_ff) begin
               if (real_ff <= TIME_W'(span)) begin
                  div_num_in = span - real_ff[31:0];
                  state_in = (arrest_ff == '0) ? ST_TICK_IDX : ST_DIV;
               end else begin
                  resume_in = 1'b0;
                  real_in = warped_ff;
               end
            end else begin
               warped_in = real_ff;
            end
         end
         ST_TICK_IDX: begin
            tab_idx_in = (idx_wide > (IDX_W + 2)'(TAB_LAST)) ? TAB_LAST
                         : idx_wide[IDX_W-1:0];
            state_in = ST_TICK_ROM;
         end
         ST_TICK_ROM: begin
            state_in = ST_TICK_ADD;
         end
         ST_TICK_ADD: begin
            warped_in = sat_add(warped_ff, TIME_W'(tab_val_ff));
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_time_in = warped_ff;
               rsp_stopped_in = halted_ff;
               rsp_stopping_in = stop_ff;
               rsp_resuming_in = resume_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_ff <= MIN_ARREST_RESET;
         spac_ff <= SPAC_RESET;
         valid_ff <= '0;
         warped_ff <= '0;
         real_ff <= '0;
         mark_ff <= '0;
         arrest_ff <= '0;
         halted_ff <= 1'b0;
         stop_ff <= 1'b0;
         resume_ff <= 1'b0;
         fresh_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rsp_time_ff <= '0;
         rsp_stopped_ff <= 1'b0;
         rsp_stopping_ff <= 1'b0;
         rsp_resuming_ff <= 1'b0;
         rd_live_ff <= 1'b0;
         scan_cnt_ff <= '0;
         div_cnt_ff <= '0;
         div_stop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         min_ff <= min_in;
         spac_ff <= spac_in;
         valid_ff <= valid_in;
         warped_ff <= warped_in;
         real_ff <= real_in;
         mark_ff <= mark_in;
         arrest_ff <= arrest_in;
         halted_ff <= halted_in;
         stop_ff <= stop_in;
         resume_ff <= resume_in;
         fresh_ff <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_time_ff <= rsp_time_in;
         rsp_stopped_ff <= rsp_stopped_in;
         rsp_stopping_ff <= rsp_stopping_in;
         rsp_resuming_ff <= rsp_resuming_in;
         rd_live_ff <= rd_live_in;
         scan_cnt_ff <= scan_cnt_in;
         div_cnt_ff <= div_cnt_in;
         div_stop_ff <= div_stop_in;
      end
   end

   always_ff @(posedge clock) begin
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      max_ff <= max_in;
      tab_idx_ff <= tab_idx_in;
      tab_val_ff <= EXP_TAB[tab_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         speed_mem[mem_addr] <= req_motor_speed;
      end
      rd_data_ff <= speed_mem[scan_cnt_ff];
      rd_ok_ff <= valid_ff[scan_cnt_ff];
   end

   `ASSERT_PROP(a_rsp_from_finish, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
   `ASSERT_PROP(a_div_starts_clean, clock, reset,
      (state_ff == ST_DIV) && ($past(state_ff) != ST_DIV) |-> (div_cnt_ff == 5'd0))
   `ASSERT_PROP(a_arrest_floor, clock, reset,
      (state_ff == ST_STOP_FIN) |=> (arrest_ff >= $past(min_ff)))
   `ASSERT_NEVER(a_read_in_scan, clock, reset,
      rd_live_ff && (state_ff != ST_SCAN) && (state_ff != ST_SCAN_LAST))

endmodule

`default_nettype wire
